/* sv/sfl_pkg.sv */
// Shared types and constants for the sorted free-list page allocator.
package sfl_pkg;

   localparam int PAGE_CAPACITY = 1024;
   localparam int PAGE_W        = 10;
   localparam int COUNT_W       = $clog2(PAGE_CAPACITY + 1);

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_BAD    = 2'd2;
   localparam logic [1:0] STATUS_DOUBLE = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC_CHECK,
      S_ALLOC_LOAD,
      S_WALK_CHECK,
      S_WALK_LOAD,
      S_INS_PREV,
      S_INS_PAGE,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      PSEL_ZERO,
      PSEL_COUNT,
      PSEL_HEAD
   } page_sel_type;

   typedef struct packed {
      logic         load_req;
      logic         alloc_extend;
      logic         alloc_read;
      logic         alloc_pop;
      logic         walk_read;
      logic         walk_load;
      logic         ins_prev;
      logic         ins_page;
      logic         rsp_write;
      logic [1:0]   rsp_status;
      page_sel_type rsp_page_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic head_zero;
      logic full;
      logic bad;
      logic dup;
      logic ins_here;
   } dp_status_type;

endpackage

/* sv/sorted_free_list_page_allocator.sv */
// Top level of the sorted free-list page allocator.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_type, req_page_to_free
//   rsp      out        rsp_valid / rsp_ready  rsp_page_number, rsp_status
//
// One transaction at a time. Allocate pops the list with one read of the single-port link RAM
// and extends the store, or reports it full, when the list is empty. Free walks the list
// from the head past every free page below the freed page and links the page in after them;
// each walk step is one registered link RAM read. A double free stops the walk where it finds
// the page; a bad page is refused at the first check, before any link RAM read.
// Reset empties the list and sets the count to 1; the link RAM needs no clearing.
// A stalled result holds the block; the next request is taken once it is accepted.
module sorted_free_list_page_allocator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_type,
   input  logic [sfl_pkg::PAGE_W-1:0] req_page_to_free,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [sfl_pkg::PAGE_W-1:0] rsp_page_number,
   output logic [1:0]                 rsp_status
);

   sfl_pkg::dp_cmd_type    cmd;
   sfl_pkg::dp_status_type stat;

   sfl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_type (req_type),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   sfl_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_type        (req_type),
      .req_page_to_free(req_page_to_free),
      .stat            (stat),
      .rsp_page_number (rsp_page_number),
      .rsp_status      (rsp_status)
   );

endmodule

/* sv/sfl_ram.sv */
// Generic single-port RAM with registered read.
module sfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* sv/sfl_datapath.sv */
// Datapath: list head, page count, walk pointers, link RAM and result registers.
module sfl_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  sfl_pkg::dp_cmd_type           cmd,
   input  logic                          req_type,
   input  logic [sfl_pkg::PAGE_W-1:0]    req_page_to_free,
   output sfl_pkg::dp_status_type        stat,
   output logic [sfl_pkg::PAGE_W-1:0]    rsp_page_number,
   output logic [1:0]                    rsp_status
);

   logic [sfl_pkg::PAGE_W-1:0]  head_ff, head_in;
   logic [sfl_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [sfl_pkg::PAGE_W-1:0]  cur_ff, cur_in;
   logic [sfl_pkg::PAGE_W-1:0]  nxt_ff, nxt_in;
   logic [sfl_pkg::PAGE_W-1:0]  page_ff, page_in;
   logic                        type_ff, type_in;
   logic [sfl_pkg::PAGE_W-1:0]  rsp_page_ff, rsp_page_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;

   logic                        ram_en, ram_we;
   logic [sfl_pkg::PAGE_W-1:0]  ram_addr, ram_wdata, ram_rdata;

   sfl_ram #(
      .WIDTH(sfl_pkg::PAGE_W),
      .DEPTH(sfl_pkg::PAGE_CAPACITY)
   ) u_link_ram (
      .clock(clock),
      .en   (ram_en),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   always_comb begin
      stat.head_zero = (head_ff == '0);
      stat.full      = (count_ff >= sfl_pkg::COUNT_W'(sfl_pkg::PAGE_CAPACITY));
      stat.bad       = (type_ff == sfl_pkg::REQ_FREE) &&
                       ((page_ff == '0) ||
                        (32'(page_ff) >= 32'(sfl_pkg::PAGE_CAPACITY)));
      stat.dup       = (nxt_ff == page_ff);
      stat.ins_here  = (nxt_ff == '0) || (nxt_ff > page_ff);
   end

   always_comb begin
      ram_en    = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = nxt_ff;
      ram_wdata = page_ff;
      if (cmd.alloc_read) begin
         ram_en   = 1'b1;
         ram_addr = head_ff;
      end else if (cmd.walk_read) begin
         ram_en   = 1'b1;
         ram_addr = nxt_ff;
      end else if (cmd.ins_prev) begin
         // the header link lives in head_ff, not in the RAM
         ram_en    = (cur_ff != '0);
         ram_we    = 1'b1;
         ram_addr  = cur_ff;
         ram_wdata = page_ff;
      end else if (cmd.ins_page) begin
         ram_en    = 1'b1;
         ram_we    = 1'b1;
         ram_addr  = page_ff;
         ram_wdata = nxt_ff;
      end
   end

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      nxt_in        = nxt_ff;
      page_in       = page_ff;
      type_in       = type_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.load_req) begin
         type_in = req_type;
         page_in = req_page_to_free;
         cur_in  = '0;
         nxt_in  = head_ff;
      end
      if (cmd.alloc_extend) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.alloc_pop) begin
         head_in = ram_rdata;
         if (count_ff < sfl_pkg::COUNT_W'(sfl_pkg::PAGE_CAPACITY)) begin
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.walk_read) begin
         cur_in = nxt_ff;
      end
      if (cmd.walk_load) begin
         nxt_in = ram_rdata;
      end
      if (cmd.ins_prev && (cur_ff == '0)) begin
         head_in = page_ff;
      end
      if (cmd.ins_page && (count_ff > sfl_pkg::COUNT_W'(1))) begin
         count_in = count_ff - 1'b1;
      end
      if (cmd.rsp_write) begin
         rsp_status_in = cmd.rsp_status;
         case (cmd.rsp_page_sel)
            sfl_pkg::PSEL_COUNT: rsp_page_in = count_ff[sfl_pkg::PAGE_W-1:0];
            sfl_pkg::PSEL_HEAD:  rsp_page_in = head_ff;
            default:             rsp_page_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= sfl_pkg::COUNT_W'(1);
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      nxt_ff        <= nxt_in;
      page_ff       <= page_in;
      type_ff       <= type_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_page_number = rsp_page_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

/* sv/sfl_ctrl.sv */
// Controller state machine sequencing allocate and free transactions.
module sfl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_type,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  sfl_pkg::dp_status_type stat,
   output sfl_pkg::dp_cmd_type    cmd
);

   sfl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfl_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      cmd.rsp_status   = sfl_pkg::STATUS_OK;
      cmd.rsp_page_sel = sfl_pkg::PSEL_ZERO;
      req_ready        = 1'b0;
      rsp_valid        = 1'b0;

      case (state_ff)
         sfl_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = (req_type == sfl_pkg::REQ_ALLOC) ? sfl_pkg::S_ALLOC_CHECK
                                                           : sfl_pkg::S_WALK_CHECK;
            end
         end
         sfl_pkg::S_ALLOC_CHECK: begin
            cmd.rsp_write = 1'b1;
            if (!stat.head_zero) begin
               // pop the lowest free page; its link becomes the new head
               cmd.alloc_read   = 1'b1;
               cmd.rsp_page_sel = sfl_pkg::PSEL_HEAD;
               state_in = sfl_pkg::S_ALLOC_LOAD;
            end else if (stat.full) begin
               cmd.rsp_status = sfl_pkg::STATUS_FULL;
               state_in = sfl_pkg::S_RESP;
            end else begin
               cmd.alloc_extend = 1'b1;
               cmd.rsp_page_sel = sfl_pkg::PSEL_COUNT;
               state_in = sfl_pkg::S_RESP;
            end
         end
         sfl_pkg::S_ALLOC_LOAD: begin
            cmd.alloc_pop = 1'b1;
            state_in = sfl_pkg::S_RESP;
         end
         sfl_pkg::S_WALK_CHECK: begin
            if (stat.bad) begin
               cmd.rsp_write  = 1'b1;
               cmd.rsp_status = sfl_pkg::STATUS_BAD;
               state_in = sfl_pkg::S_RESP;
            end else if (stat.dup) begin
               cmd.rsp_write  = 1'b1;
               cmd.rsp_status = sfl_pkg::STATUS_DOUBLE;
               state_in = sfl_pkg::S_RESP;
            end else if (stat.ins_here) begin
               state_in = sfl_pkg::S_INS_PREV;
            end else begin
               cmd.walk_read = 1'b1;
               state_in = sfl_pkg::S_WALK_LOAD;
            end
         end
         sfl_pkg::S_WALK_LOAD: begin
            cmd.walk_load = 1'b1;
            state_in = sfl_pkg::S_WALK_CHECK;
         end
         sfl_pkg::S_INS_PREV: begin
            cmd.ins_prev = 1'b1;
            state_in = sfl_pkg::S_INS_PAGE;
         end
         sfl_pkg::S_INS_PAGE: begin
            cmd.ins_page  = 1'b1;
            cmd.rsp_write = 1'b1;
            state_in = sfl_pkg::S_RESP;
         end
         sfl_pkg::S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = sfl_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sfl_pkg::S_IDLE;
         end
      endcase
   end

endmodule

/* bench/tb.sv */
// Testbench for the sorted free-list page allocator: directed table, then random traffic.
`timescale 1ns / 100ps

module tb;

   localparam int  CHURN_ITEMS = 20;
   localparam int  TOP_ITEMS   = 20;
   localparam int  FULL_WANTED = 4;
   localparam int  FILL_GUARD  = 3000;
   localparam int  HOLD_AT     = 180;
   localparam int  HOLD_CYCLES = 300;
   localparam int  SETTLE      = 16;
   // Allows a worst-case walk of the whole list for every item, several times over.
   localparam real TIMEOUT_NS  = 150_000_000.0;

   typedef struct packed {
      logic                       kind;
      logic [sfl_pkg::PAGE_W-1:0] page;
      logic                       known;
      logic [sfl_pkg::PAGE_W-1:0] want_page;
      logic [1:0]                 want_status;
   } stim_row_type;

   typedef struct packed {
      logic [sfl_pkg::PAGE_W-1:0] page;
      logic [1:0]                 status;
   } reply_type;

   typedef enum int {MIX_CHURN, MIX_FILL, MIX_TOP} mix_type;

   localparam stim_row_type DIRECTED [25] = '{
      '{sfl_pkg::REQ_ALLOC, 10'd0,    1'b1, 10'd1, sfl_pkg::STATUS_OK},
      '{sfl_pkg::REQ_ALLOC, 10'd1023, 1'b1, 10'd2, sfl_pkg::STATUS_OK},
      '{sfl_pkg::REQ_ALLOC, 10'd0,    1'b0, 10'd0, sfl_pkg::STATUS_OK},
      '{sfl_pkg::REQ_ALLOC, 10'd0,    1'b0, 10'd0, sfl_pkg::STATUS_OK},
      '{sfl_pkg::REQ_FREE,  10'd0,    1'b1, 10'd0, sfl_pkg::STATUS_BAD},
      '{sfl_pkg::REQ_FREE,  10'd2,    1'b1, 10'd0, sfl_pkg::STATUS_OK},
      '{sfl_pkg::REQ_FREE,  10'd2,    1'b1, 10'd0, sfl_pkg::STATUS_DOUBLE},
      '{sfl_pkg::REQ_FREE,  10'd4,    1'b0, 10'd0, sfl_pkg::STATUS_OK},
      '{sfl_pkg::REQ_FREE,  10'd3,    1'b0, 10'd0, sfl_pkg::STATUS_OK},
      '{sfl_pkg::REQ_FREE,  10'd1,    1'b0, 10'd0, sfl_pkg::STATUS_OK},
      '{sfl_pkg::REQ_FREE,  10'd1,    1'b1, 10'd0, sfl_pkg::STATUS_DOUBLE},
      '{sfl_pkg::REQ_FREE,  10'd4,    1'b1, 10'd0, sfl_pkg::STATUS_DOUBLE},
      '{sfl_pkg::REQ_FREE,  10'd1023, 1'b0, 10'd0, sfl_pkg::STATUS_OK},
      '{sfl_pkg::REQ_ALLOC, 10'd0,    1'b0, 10'd0, sfl_pkg::STATUS_OK},
      '{sfl_pkg::REQ_ALLOC, 10'd0,    1'b0, 10'd0, sfl_pkg::STATUS_OK},
      '{sfl_pkg::REQ_FREE,  10'd1023, 1'b1, 10'd0, sfl_pkg::STATUS_DOUBLE},
      '{sfl_pkg::REQ_FREE,  10'd512,  1'b0, 10'd0, sfl_pkg::STATUS_OK},
      '{sfl_pkg::REQ_ALLOC, 10'd0,    1'b0, 10'd0, sfl_pkg::STATUS_OK},
      '{sfl_pkg::REQ_ALLOC, 10'd0,    1'b0, 10'd0, sfl_pkg::STATUS_OK},
      '{sfl_pkg::REQ_ALLOC, 10'd0,    1'b0, 10'd0, sfl_pkg::STATUS_OK},
      '{sfl_pkg::REQ_ALLOC, 10'd0,    1'b0, 10'd0, sfl_pkg::STATUS_OK},
      '{sfl_pkg::REQ_ALLOC, 10'd0,    1'b0, 10'd0, sfl_pkg::STATUS_OK},
      '{sfl_pkg::REQ_FREE,  10'd5,    1'b0, 10'd0, sfl_pkg::STATUS_OK},
      '{sfl_pkg::REQ_ALLOC, 10'd1023, 1'b0, 10'd0, sfl_pkg::STATUS_OK},
      '{sfl_pkg::REQ_FREE,  10'h155,  1'b0, 10'd0, sfl_pkg::STATUS_OK}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_type = sfl_pkg::REQ_ALLOC;
   logic [sfl_pkg::PAGE_W-1:0] req_page_to_free = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [sfl_pkg::PAGE_W-1:0] rsp_page_number;
   logic [1:0]                 rsp_status;

   // Predicted allocator state
   logic [sfl_pkg::PAGE_W-1:0]  free_link [sfl_pkg::PAGE_CAPACITY];
   logic [sfl_pkg::COUNT_W-1:0] used_count;

   reply_type                  owed_replies [$];
   logic [sfl_pkg::PAGE_W-1:0] held_pages [$];
   int                         errors    = 0;
   int                         sent      = 0;
   int                         got       = 0;
   int                         full_seen = 0;

   sorted_free_list_page_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_page_to_free (req_page_to_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_page_number  (rsp_page_number),
      .rsp_status       (rsp_status)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

   function automatic void clear_pages();
      for (int i = 0; i < sfl_pkg::PAGE_CAPACITY; i++) free_link[i] = '0;
      used_count = sfl_pkg::COUNT_W'(1);
   endfunction

   // Apply one request to the predicted state and return the reply it earns.
   function automatic reply_type apply_page_request(input logic kind,
                                                    input logic [sfl_pkg::PAGE_W-1:0] pg);
      reply_type                  r;
      logic [sfl_pkg::PAGE_W-1:0] cur;
      logic [sfl_pkg::PAGE_W-1:0] nxt;
      r.page   = '0;
      r.status = sfl_pkg::STATUS_OK;
      if (kind == sfl_pkg::REQ_ALLOC) begin
         if (free_link[0] == '0) begin
            if (used_count >= sfl_pkg::PAGE_CAPACITY) begin
               r.status = sfl_pkg::STATUS_FULL;
            end else begin
               r.page     = used_count[sfl_pkg::PAGE_W-1:0];
               used_count = used_count + 1'b1;
            end
         end else begin
            r.page       = free_link[0];
            free_link[0] = free_link[r.page];
            if (used_count < sfl_pkg::PAGE_CAPACITY) used_count = used_count + 1'b1;
         end
         return r;
      end
      if (pg == '0 || int'(pg) >= sfl_pkg::PAGE_CAPACITY) begin
         r.status = sfl_pkg::STATUS_BAD;
         return r;
      end
      cur = '0;
      for (int step = 0; step < sfl_pkg::PAGE_CAPACITY; step++) begin
         nxt = free_link[cur];
         if (nxt == pg) begin
            r.status = sfl_pkg::STATUS_DOUBLE;
            return r;
         end
         if (nxt == '0 || nxt > pg) begin
            free_link[cur] = pg;
            free_link[pg]  = nxt;
            if (used_count > 1) used_count = used_count - 1'b1;
            return r;
         end
         cur = nxt;
      end
      return r;
   endfunction

   // Half allocs, nearly all when filling; frees mostly of held pages, else listed, 0 or noise.
   function automatic void draw_request(input mix_type mix, output logic kind,
                                        output logic [sfl_pkg::PAGE_W-1:0] pg);
      bit [31:0]                  raw;
      int                         roll;
      int                         pick;
      int                         idx;
      int                         hops;
      logic [sfl_pkg::PAGE_W-1:0] cur;
      raw  = $urandom;
      pg   = raw[sfl_pkg::PAGE_W-1:0];
      roll = $urandom_range(0, 99);
      if (roll < ((mix == MIX_FILL) ? 99 : 50)) begin
         kind = sfl_pkg::REQ_ALLOC;
         return;
      end
      kind = sfl_pkg::REQ_FREE;
      pick = (mix == MIX_FILL) ? 0 : $urandom_range(0, 99);
      if (pick < 75 && held_pages.size() > 0) begin
         idx = $urandom_range(0, held_pages.size() - 1);
         pg  = held_pages[idx];
         held_pages.delete(idx);
      end else if (pick < 88 && free_link[0] != '0) begin
         hops = $urandom_range(0, 15);
         cur  = free_link[0];
         while (hops > 0 && free_link[cur] != '0) begin
            cur  = free_link[cur];
            hops = hops - 1;
         end
         pg = cur;
      end else if (pick < 94) begin
         pg = '0;
      end
   endfunction

   task automatic issue(input logic kind, input logic [sfl_pkg::PAGE_W-1:0] pg,
                        input logic known, input reply_type typed);
      int        gap;
      reply_type r;
      gap = (((sent / 40) % 4) == 3) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_page_to_free <= pg;
      do @(posedge clock); while (!req_ready);
      r = apply_page_request(kind, pg);
      if (kind == sfl_pkg::REQ_ALLOC && r.status == sfl_pkg::STATUS_OK) begin
         held_pages.push_back(r.page);
      end
      if (r.status == sfl_pkg::STATUS_FULL) full_seen++;
      owed_replies.push_back(known ? typed : r);
      sent++;
   endtask

   // Response side: random stalls, one long hold-off that backs the block up.
   initial begin
      int        gap;
      reply_type want;
      wait (reset == 1'b0);
      forever begin
         if (got == HOLD_AT) gap = HOLD_CYCLES;
         else gap = (((got / 55) % 4) == 2) ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (owed_replies.size() == 0) begin
            errors++;
            $display("%0t: response with nothing expected: page %0d status %0d",
                     $time, rsp_page_number, rsp_status);
         end else begin
            want = owed_replies.pop_front();
            if (rsp_page_number !== want.page) begin
               errors++;
               $display("%0t: page_number expected %0d actual %0d",
                        $time, want.page, rsp_page_number);
            end
            if (rsp_status !== want.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
            end
         end
         got++;
      end
   end

   initial begin
      logic                       kind;
      logic [sfl_pkg::PAGE_W-1:0] pg;
      reply_type                  typed;
      clear_pages();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) begin
         typed.page   = DIRECTED[i].want_page;
         typed.status = DIRECTED[i].want_status;
         issue(DIRECTED[i].kind, DIRECTED[i].page, DIRECTED[i].known, typed);
      end

      typed = '0;
      for (int n = 0; n < CHURN_ITEMS; n++) begin
         draw_request(MIX_CHURN, kind, pg);
         issue(kind, pg, 1'b0, typed);
      end
      // Push the store to capacity and keep asking past it.
      while (full_seen < FULL_WANTED && sent < FILL_GUARD) begin
         draw_request(MIX_FILL, kind, pg);
         issue(kind, pg, 1'b0, typed);
      end
      for (int n = 0; n < TOP_ITEMS; n++) begin
         draw_request(MIX_TOP, kind, pg);
         issue(kind, pg, 1'b0, typed);
      end
      req_valid <= 1'b0;

      while (owed_replies.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
